// File: hdl/timestamp_mutex_arbiter_core_defines.svh
// Assertion helpers shared by the arbiter RTL.
`ifndef TIMESTAMP_MUTEX_ARBITER_CORE_DEFINES_SVH
`define TIMESTAMP_MUTEX_ARBITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tsma_pkg.sv
`timescale 1ns / 1ps

package tsma_pkg;

    // Request kinds.
    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Per-process state codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REQ  = 2'd1;
    localparam logic [1:0] ST_IN   = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_REPLY     = 3'd0;
    localparam logic [2:0] EV_DEFER     = 3'd1;
    localparam logic [2:0] EV_ENTERED   = 3'd2;
    localparam logic [2:0] EV_WAITING   = 3'd3;
    localparam logic [2:0] EV_RELEASED  = 3'd4;
    localparam logic [2:0] EV_DEF_REPLY = 3'd5;
    localparam logic [2:0] EV_BAD_ID    = 3'd6;

    localparam logic [4:0] CFG_COUNT_RESET = 5'd3;
    localparam logic [4:0] CFG_COUNT_MIN   = 5'd2;

    typedef struct packed {
        logic        kind;
        logic [3:0]  proc_id;
        logic [15:0] stamp;
    } t_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] from_proc;
        logic [3:0] to_proc;
        logic       last;
    } t_out;

endpackage

// File: hdl/tsma_grant.sv
`timescale 1ns / 1ps

module tsma_grant #(
    parameter int STAMP_BITS = 16
) (
    input  logic [1:0]            i_other_state,
    input  logic [STAMP_BITS-1:0] i_other_stamp,
    input  logic [STAMP_BITS-1:0] i_req_stamp,
    input  logic                  i_req_lower_id,
    output logic                  o_grant
);

    always_comb begin
        case (i_other_state)
            tsma_pkg::ST_IDLE: begin
                o_grant = 1'b1;
            end
            tsma_pkg::ST_REQ: begin
                // The older request wins; equal stamps go to the lower id.
                o_grant = (i_req_stamp < i_other_stamp) ||
                          ((i_req_stamp == i_other_stamp) && i_req_lower_id);
            end
            default: begin
                o_grant = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/timestamp_mutex_arbiter_core.sv
// Channel   Signals                                   Direction
// cfg       i_cfg_valid / o_cfg_ready / i_cfg_data    in  (process count)
// in        i_in_valid / o_in_ready / i_in_data       in  (acquire or release)
// out       o_out_valid / i_out_ready / o_out_data    out (one event per beat)
//
// An acquire is latched, walked once per process id through the shared grant compare,
// and closed with the entered or waiting event.
// A release emits its released event and then scans ids up to the last owed reply;
// a bad id emits a single bad-id event.
// Outside idle, the sequencer advances only when the output register is free or being drained.
// Synchronous active-low reset idles every process and clears all deferred bits.
`timescale 1ns / 1ps
`include "timestamp_mutex_arbiter_core_defines.svh"

module timestamp_mutex_arbiter_core #(
    parameter int MAX_PROCS  = 16,
    parameter int STAMP_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [4:0]      i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tsma_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tsma_pkg::t_out  o_out_data
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_DONE = 6'b000100,
        S_REL  = 6'b001000,
        S_SCAN = 6'b010000,
        S_BAD  = 6'b100000
    } t_seq;

    t_seq                  r_state, n_state;
    logic [4:0]            r_cfg;
    logic [CW-1:0]         r_cnt, r_idx, n_idx;
    logic [IW-1:0]         r_pid;
    logic [3:0]            r_pid_raw;
    logic [STAMP_BITS-1:0] r_ts;
    logic                  r_all, n_all;
    logic [1:0]            r_pstate [MAX_PROCS];
    logic [STAMP_BITS-1:0] r_stamp  [MAX_PROCS];
    logic [MAX_PROCS-1:0]  r_defer  [MAX_PROCS];
    logic                  r_out_valid;
    tsma_pkg::t_out        r_out;

    logic                  accept, adv, bad_id, grant, emit;
    logic [CW-1:0]         cnt_eff;
    logic [31:0]           in_pid_ext, in_stamp_ext, idx_ext;
    logic [IW-1:0]         in_pid_ix, idx_ix, ps_ix;
    logic [STAMP_BITS-1:0] in_ts;
    logic [3:0]            idx4;
    logic [MAX_PROCS-1:0]  row;
    logic                  rem_all, rem_after;
    logic                  ps_we, df_set, df_clr;
    logic [1:0]            ps_val;
    tsma_pkg::t_out        em_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign accept = i_in_valid && o_in_ready;
    assign adv    = !r_out_valid || i_out_ready;

    // Out-of-range counts are clamped into the supported range.
    always_comb begin
        if (r_cfg < tsma_pkg::CFG_COUNT_MIN) begin
            cnt_eff = CW'(2);
        end else if (int'(r_cfg) > MAX_PROCS) begin
            cnt_eff = CW'(MAX_PROCS);
        end else begin
            cnt_eff = CW'(r_cfg);
        end
    end

    assign in_pid_ext   = 32'(i_in_data.proc_id);
    assign in_pid_ix    = in_pid_ext[IW-1:0];
    assign bad_id       = in_pid_ext >= 32'(cnt_eff);
    assign in_stamp_ext = 32'(i_in_data.stamp);
    assign in_ts        = in_stamp_ext[STAMP_BITS-1:0];
    assign idx_ext      = 32'(r_idx);
    assign idx_ix       = idx_ext[IW-1:0];
    assign idx4         = idx_ext[3:0];
    assign row          = r_defer[r_pid];

    tsma_grant #(
        .STAMP_BITS (STAMP_BITS)
    ) u_grant (
        .i_other_state  (r_pstate[idx_ix]),
        .i_other_stamp  (r_stamp[idx_ix]),
        .i_req_stamp    (r_ts),
        .i_req_lower_id (CW'(r_pid) < r_idx),
        .o_grant        (grant)
    );

    // Pending deferred bits inside the active count, overall and past the scan index.
    always_comb begin
        rem_all   = 1'b0;
        rem_after = 1'b0;
        for (int j = 0; j < MAX_PROCS; j++) begin
            if (row[j] && (j < int'(r_cnt))) begin
                rem_all = 1'b1;
                if (j > int'(r_idx)) begin
                    rem_after = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_all   = r_all;
        emit    = 1'b0;
        em_data = '0;
        ps_we   = 1'b0;
        ps_ix   = r_pid;
        ps_val  = tsma_pkg::ST_IDLE;
        df_set  = 1'b0;
        df_clr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_all = 1'b1;
                    ps_ix = in_pid_ix;
                    if (bad_id) begin
                        n_state = S_BAD;
                    end else if (i_in_data.kind == tsma_pkg::KIND_ACQUIRE) begin
                        ps_we   = 1'b1;
                        ps_val  = tsma_pkg::ST_REQ;
                        n_state = S_WALK;
                    end else begin
                        ps_we   = 1'b1;
                        ps_val  = tsma_pkg::ST_IDLE;
                        n_state = S_REL;
                    end
                end
            end
            S_WALK: begin
                if (adv) begin
                    if (r_idx != CW'(r_pid)) begin
                        emit              = 1'b1;
                        em_data.event_res = grant ? tsma_pkg::EV_REPLY : tsma_pkg::EV_DEFER;
                        em_data.from_proc = idx4;
                        em_data.to_proc   = r_pid_raw;
                        if (!grant) begin
                            df_set = 1'b1;
                            n_all  = 1'b0;
                        end
                    end
                    if (r_idx == r_cnt - CW'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (adv) begin
                    emit              = 1'b1;
                    em_data.event_res = r_all ? tsma_pkg::EV_ENTERED : tsma_pkg::EV_WAITING;
                    em_data.from_proc = r_pid_raw;
                    em_data.last      = 1'b1;
                    ps_we             = r_all;
                    ps_val            = tsma_pkg::ST_IN;
                    n_state           = S_IDLE;
                end
            end
            S_REL: begin
                if (adv) begin
                    emit              = 1'b1;
                    em_data.event_res = tsma_pkg::EV_RELEASED;
                    em_data.from_proc = r_pid_raw;
                    em_data.last      = !rem_all;
                    n_idx             = '0;
                    n_state           = rem_all ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    if (row[idx_ix]) begin
                        emit              = 1'b1;
                        em_data.event_res = tsma_pkg::EV_DEF_REPLY;
                        em_data.from_proc = r_pid_raw;
                        em_data.to_proc   = idx4;
                        em_data.last      = !rem_after;
                        df_clr            = 1'b1;
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = rem_after ? S_SCAN : S_IDLE;
                end
            end
            S_BAD: begin
                if (adv) begin
                    emit              = 1'b1;
                    em_data.event_res = tsma_pkg::EV_BAD_ID;
                    em_data.from_proc = r_pid_raw;
                    em_data.last      = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= tsma_pkg::CFG_COUNT_RESET;
            r_idx       <= '0;
            r_all       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < MAX_PROCS; p++) begin
                r_pstate[p] <= tsma_pkg::ST_IDLE;
                r_defer[p]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_all   <= n_all;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ps_we) begin
                r_pstate[ps_ix] <= ps_val;
            end
            if (df_set) begin
                r_defer[idx_ix][r_pid] <= 1'b1;
            end
            if (df_clr) begin
                r_defer[r_pid][idx_ix] <= 1'b0;
            end
        end
    end

    // Request payload and stamps; a stamp is only consulted once its process requests.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pid     <= in_pid_ix;
            r_pid_raw <= i_in_data.proc_id;
            r_ts      <= in_ts;
            r_cnt     <= cnt_eff;
            if (!bad_id && (i_in_data.kind == tsma_pkg::KIND_ACQUIRE)) begin
                r_stamp[in_pid_ix] <= in_ts;
            end
        end
        if (emit) begin
            r_out <= em_data;
        end
    end

    `TSMA_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, emit && em_data.last, r_state == S_IDLE, "sequencer did not idle after the final event")
    `TSMA_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == S_WALK, r_idx < r_cnt, "walk index beyond process count")
    `TSMA_ASSERT_IMPL(a_requester_pending, i_clk, i_rst_n, r_state == S_WALK || r_state == S_DONE, r_pstate[r_pid] == tsma_pkg::ST_REQ, "requester left requesting state during walk")

endmodule

// File: dv/timestamp_mutex_arbiter_core_tb.sv
`timescale 1ns / 1ps

module timestamp_mutex_arbiter_core_tb;

    localparam int NPROC         = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    // Mirror of the arbiter: per-process mode, held stamp and owed replies.
    class mutex_scoreboard;
        logic [1:0]      proc_mode [NPROC];
        logic [15:0]     held_stamp [NPROC];
        logic [15:0]     owed_replies [NPROC];
        logic [4:0]      count_reg;
        tsma_pkg::t_out  expected_events [$];
        int              errors;

        function new();
            count_reg = tsma_pkg::CFG_COUNT_RESET;
            errors = 0;
            for (int i = 0; i < NPROC; i++) begin
                proc_mode[i] = tsma_pkg::ST_IDLE;
                held_stamp[i] = '0;
                owed_replies[i] = '0;
            end
        endfunction

        function int unsigned active_count();
            int unsigned cnt;
            cnt = count_reg;
            if (cnt < tsma_pkg::CFG_COUNT_MIN) cnt = tsma_pkg::CFG_COUNT_MIN;
            if (cnt > NPROC) cnt = NPROC;
            return cnt;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void push_event(logic [2:0] ev, int unsigned src, int unsigned dst);
            tsma_pkg::t_out e;
            e.event_res = ev;
            e.from_proc = src[3:0];
            e.to_proc   = dst[3:0];
            e.last      = 1'b0;
            expected_events.push_back(e);
        endfunction

        function void note_request(tsma_pkg::t_in r);
            int unsigned cnt;
            int unsigned pid;
            int unsigned replies;
            bit          grant;
            cnt = active_count();
            pid = r.proc_id;
            replies = 0;
            if (pid >= cnt) begin
                push_event(tsma_pkg::EV_BAD_ID, pid, 0);
            end else if (r.kind == tsma_pkg::KIND_ACQUIRE) begin
                proc_mode[pid] = tsma_pkg::ST_REQ;
                held_stamp[pid] = r.stamp;
                for (int unsigned i = 0; i < cnt; i++) begin
                    if (i == pid) continue;
                    // A process that is inside never grants; a requesting one
                    // grants only to an older request, ties going to the lower id.
                    grant = (proc_mode[i] == tsma_pkg::ST_IDLE) ||
                            (proc_mode[i] == tsma_pkg::ST_REQ &&
                             (r.stamp < held_stamp[i] ||
                              (r.stamp == held_stamp[i] && pid < i)));
                    if (grant) begin
                        push_event(tsma_pkg::EV_REPLY, i, pid);
                        replies++;
                    end else begin
                        push_event(tsma_pkg::EV_DEFER, i, pid);
                        owed_replies[i][pid] = 1'b1;
                    end
                end
                if (replies == cnt - 1) begin
                    proc_mode[pid] = tsma_pkg::ST_IN;
                    push_event(tsma_pkg::EV_ENTERED, pid, 0);
                end else begin
                    push_event(tsma_pkg::EV_WAITING, pid, 0);
                end
            end else begin
                proc_mode[pid] = tsma_pkg::ST_IDLE;
                push_event(tsma_pkg::EV_RELEASED, pid, 0);
                // Bits above the current count stay set until it covers them again.
                for (int unsigned i = 0; i < cnt; i++) begin
                    if (owed_replies[pid][i]) begin
                        owed_replies[pid][i] = 1'b0;
                        push_event(tsma_pkg::EV_DEF_REPLY, pid, i);
                    end
                end
            end
            expected_events[expected_events.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t MISMATCH %s", $time, what);
        endtask

        task check_result(tsma_pkg::t_out got);
            tsma_pkg::t_out want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d from=%0d to=%0d last=%0d",
                    got.event_res, got.from_proc, got.to_proc, got.last));
            end else begin
                want = expected_events.pop_front();
                if (got.event_res !== want.event_res)
                    report_mismatch($sformatf("event_res got %0d want %0d (from %0d)",
                        got.event_res, want.event_res, want.from_proc));
                if (got.from_proc !== want.from_proc)
                    report_mismatch($sformatf("from_proc got %0d want %0d (ev %0d)",
                        got.from_proc, want.from_proc, want.event_res));
                if (got.to_proc !== want.to_proc)
                    report_mismatch($sformatf("to_proc got %0d want %0d (ev %0d)",
                        got.to_proc, want.to_proc, want.event_res));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d (ev %0d)",
                        got.last, want.last, want.event_res));
            end
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [4:0]      i_cfg_data;
    logic            i_in_valid;
    logic            o_in_ready;
    tsma_pkg::t_in   i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    tsma_pkg::t_out  o_out_data;

    mutex_scoreboard sb;
    int              rx_mode;
    int              hold_left;
    int unsigned     rx_tick;
    logic [15:0]     lamport;
    int              cycles;

    timestamp_mutex_arbiter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic tsma_pkg::t_in make_request(logic kind, logic [3:0] pid,
                                                   logic [15:0] stamp);
        tsma_pkg::t_in r;
        r.kind = kind;
        r.proc_id = pid;
        r.stamp = stamp;
        return r;
    endfunction

    // Mostly well-formed traffic: idle processes acquire with nearby stamps so
    // that ties and ordering matter, busy ones mostly release.
    function automatic tsma_pkg::t_in pick_request(int unsigned cnt);
        tsma_pkg::t_in r;
        int unsigned   roll;
        int unsigned   pid;
        roll = $urandom_range(0, 99);
        r.stamp = 16'($urandom_range(0, 65535));
        if (roll < 10) begin
            r.kind = 1'($urandom_range(0, 1));
            r.proc_id = 4'($urandom_range(0, 15));
        end else begin
            pid = $urandom_range(0, cnt - 1);
            r.proc_id = pid[3:0];
            if (sb.proc_mode[pid] != tsma_pkg::ST_IDLE && roll < 85) begin
                r.kind = tsma_pkg::KIND_RELEASE;
            end else begin
                r.kind = tsma_pkg::KIND_ACQUIRE;
                if (roll < 95) begin
                    lamport = lamport + 16'($urandom_range(0, 2));
                    r.stamp = lamport;
                end
            end
        end
        return r;
    endfunction

    task automatic offer(tsma_pkg::t_in r);
        i_in_data <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [4:0] value);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.count_reg = value;
    endtask

    task automatic run_phase(logic [4:0] count_value, int n_items, int mode, bit hold);
        int burst_left;
        int gap;
        drain();
        write_count(count_value);
        rx_mode = mode;
        if (hold) hold_left = HOLD_CYCLES;
        burst_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (!hold && burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            offer(pick_request(sb.active_count()));
        end
    endtask

    // Receiver: ready pattern depends on the phase, with an occasional long hold.
    initial begin
        rx_tick = 0;
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_out_ready <= (rx_tick % 5) < 3;
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timestamp_mutex_arbiter_core_tb: done, errors");
        $finish;
    end

    initial begin
        sb = new();
        rx_mode = 0;
        hold_left = 0;
        lamport = '0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed traffic at the reset count of three: entry, deferral,
        // stamp ties, a repeated request, release while not inside, bad ids.
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd0, 16'd10));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd1, 16'd5));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd2, 16'd5));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd1, 16'd3));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd0, 16'hFFFF));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd2, 16'd0));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd1, 16'd0));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd3, 16'hFFFF));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd15, 16'hAAAA));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd0, 16'd0));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd1, 16'hFFFF));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd0, 16'h5555));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd1, 16'd0));

        // Deferred bits for high ids left behind when the count shrinks.
        drain();
        write_count(5'd16);
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd2, 16'd1));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd14, 16'd9));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd15, 16'd0));
        drain();
        write_count(5'd3);
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd2, 16'd0));
        offer(make_request(tsma_pkg::KIND_ACQUIRE, 4'd14, 16'd7));
        drain();
        write_count(5'd16);
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd2, 16'd0));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd14, 16'd0));
        offer(make_request(tsma_pkg::KIND_RELEASE, 4'd15, 16'd0));

        run_phase(5'd2, 40, 1, 1'b0);
        run_phase(5'd16, 45, 0, 1'b1);
        run_phase(5'd0, 40, 2, 1'b0);
        run_phase(5'd31, 40, 3, 1'b0);
        run_phase(5'd1, 40, 0, 1'b0);
        run_phase(5'd7, 40, 1, 1'b0);
        run_phase(5'd17, 40, 2, 1'b0);
        run_phase(5'($urandom_range(2, 16)), 40, 3, 1'b0);
        run_phase(5'd16, 40, 1, 1'b0);
        run_phase(5'd3, 45, 0, 1'b0);

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("timestamp_mutex_arbiter_core_tb: done, clean");
        end else begin
            $display("timestamp_mutex_arbiter_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tsma_pkg.sv
hdl/tsma_grant.sv
hdl/timestamp_mutex_arbiter_core.sv
dv/timestamp_mutex_arbiter_core_tb.sv
